// File: rtl/core/double_ended_queue_assert.svh
// assertion macros shared by the deque rtl
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DEQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// next-cycle implication, checked outside reset
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`endif

// File: rtl/core/deq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

    localparam int DEPTH_DEFAULT = 256;
    localparam int DATA_W        = 32;
    localparam int OCC_W         = 9;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

`default_nettype wire

// File: rtl/core/deq_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module deq_mem #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  wire                                clk,
    input  wire                                wr_en,
    input  wire  [$clog2(DEPTH)-1:0]           wr_addr,
    input  wire  signed [deq_pkg::DATA_W-1:0]  wr_data,
    input  wire                                rd_en,
    input  wire  [$clog2(DEPTH)-1:0]           rd_addr,
    output logic signed [deq_pkg::DATA_W-1:0]  rd_data
);

    logic signed [deq_pkg::DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/double_ended_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   | handshake           | payload
// ----------+---------------------+------------------------------------
// request   | start, busy         | opcode, push_value
// result    | done (one cycle)    | popped_value, status, occupancy
//
// one request is taken per cycle; busy never rises in this design
// the result of a request shows in the cycle after acceptance; the popped
// value comes from the registered read of the entry memory
// a push writes its entry at the accepting edge, so a pop in the very next
// cycle reads the new value without forwarding
// reset (rst_n, async, active low) empties the deque; entries stay unset
// the receiver cannot stall: done is a one-cycle strobe

module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                start,
    output logic                               busy,
    input  wire  [1:0]                         opcode,
    input  wire  signed [deq_pkg::DATA_W-1:0]  push_value,
    output logic                               done,
    output logic signed [deq_pkg::DATA_W-1:0]  popped_value,
    output logic [1:0]                         status,
    output logic [deq_pkg::OCC_W-1:0]          occupancy
);

`include "double_ended_queue_assert.svh"

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    // ring pointers and occupancy count
    logic [IDX_W-1:0] front_reg, front_next;
    logic [IDX_W-1:0] back_reg, back_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // result stage
    logic              done_reg;
    logic              pop_ok_reg;
    deq_pkg::status_t  status_reg, status_next;

    deq_pkg::op_t      op;
    logic              accept;
    logic              pop_ok;
    logic [IDX_W-1:0]  front_prev, front_succ, back_prev, back_succ;

    // memory ports
    logic                               wr_en;
    logic [IDX_W-1:0]                   wr_addr;
    logic                               rd_en;
    logic [IDX_W-1:0]                   rd_addr;
    logic signed [deq_pkg::DATA_W-1:0]  rd_data;

    // widened count so occupancy is the low nine bits at any depth
    logic [CNT_W+deq_pkg::OCC_W-1:0] occ_ext;

    // ring invariant: front plus count wraps to back
    logic [CNT_W:0] ring_sum;
    logic [CNT_W:0] ring_wrap;

    assign busy   = 1'b0;
    assign accept = start & ~busy;
    assign op     = deq_pkg::op_t'(opcode);

    // neighbors on the ring, wrapping at any depth
    assign front_prev = (front_reg == '0) ? LAST_IDX : front_reg - 1'b1;
    assign front_succ = (front_reg == LAST_IDX) ? '0 : front_reg + 1'b1;
    assign back_prev  = (back_reg == '0) ? LAST_IDX : back_reg - 1'b1;
    assign back_succ  = (back_reg == LAST_IDX) ? '0 : back_reg + 1'b1;

    always_comb
    begin
        front_next  = front_reg;
        back_next   = back_reg;
        count_next  = count_reg;
        status_next = deq_pkg::ST_OK;
        pop_ok      = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = back_reg;
        rd_en       = 1'b0;
        rd_addr     = front_reg;

        if (accept)
        begin
            case (op)
                deq_pkg::OP_PUSH_FRONT:
                begin
                    if (count_reg == FULL_CNT)
                    begin
                        status_next = deq_pkg::ST_FULL;
                    end
                    else
                    begin
                        // step front back, then store there
                        front_next = front_prev;
                        wr_en      = 1'b1;
                        wr_addr    = front_prev;
                        count_next = count_reg + 1'b1;
                    end
                end
                deq_pkg::OP_PUSH_BACK:
                begin
                    if (count_reg == FULL_CNT)
                    begin
                        status_next = deq_pkg::ST_FULL;
                    end
                    else
                    begin
                        // store at back, then step back forward
                        wr_en      = 1'b1;
                        wr_addr    = back_reg;
                        back_next  = back_succ;
                        count_next = count_reg + 1'b1;
                    end
                end
                deq_pkg::OP_POP_FRONT:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = deq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = front_reg;
                        pop_ok     = 1'b1;
                        front_next = front_succ;
                        count_next = count_reg - 1'b1;
                    end
                end
                deq_pkg::OP_POP_BACK:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = deq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        // back points one past the last entry
                        rd_en      = 1'b1;
                        rd_addr    = back_prev;
                        pop_ok     = 1'b1;
                        back_next  = back_prev;
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    status_next = deq_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg  <= '0;
            back_reg   <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            pop_ok_reg <= 1'b0;
            status_reg <= deq_pkg::ST_OK;
        end
        else
        begin
            front_reg  <= front_next;
            back_reg   <= back_next;
            count_reg  <= count_next;
            done_reg   <= accept;
            pop_ok_reg <= pop_ok;
            status_reg <= status_next;
        end
    end

    deq_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (push_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // result drive: count_reg already holds the state after the request
    assign occ_ext      = (CNT_W + deq_pkg::OCC_W)'(count_reg);
    assign done         = done_reg;
    assign popped_value = pop_ok_reg ? rd_data : '0;
    assign status       = status_reg;
    assign occupancy    = occ_ext[deq_pkg::OCC_W-1:0];

    assign ring_sum  = (CNT_W + 1)'(front_reg) + (CNT_W + 1)'(count_reg);
    assign ring_wrap = (ring_sum >= (CNT_W + 1)'(DEPTH)) ?
                       ring_sum - (CNT_W + 1)'(DEPTH) : ring_sum;

    `DEQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= FULL_CNT)
    `DEQ_ASSERT_NOW(a_ring_consistent, clk, rst_n, 1'b1, ring_wrap[IDX_W-1:0] == back_reg)
    `DEQ_ASSERT_NEXT(a_one_result, clk, rst_n, accept, done)
    `DEQ_ASSERT_NEXT(a_push_grows, clk, rst_n, accept && (op == deq_pkg::OP_PUSH_FRONT || op == deq_pkg::OP_PUSH_BACK) && count_reg != FULL_CNT, count_reg == $past(count_reg) + 1'b1)
    `DEQ_ASSERT_NOW(a_full_flag, clk, rst_n, done && status == deq_pkg::ST_FULL, count_reg == FULL_CNT)

endmodule

`default_nettype wire

// File: tb/deque_checker.sv
`timescale 1ns / 1ps

// watches the request and result channels, tracks the deque contents and
// compares every result with the oldest outstanding prediction
module deque_checker
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       start,
    input  wire                       busy,
    input  wire  [1:0]                opcode,
    input  wire  signed [DATA_W-1:0]  push_value,
    input  wire                       done,
    input  wire  signed [DATA_W-1:0]  popped_value,
    input  wire  [1:0]                status,
    input  wire  [OCC_W-1:0]          occupancy,
    output int                        fail_count,
    output int                        pending,
    output int                        checked,
    output int                        full_refusals,
    output int                        empty_refusals
);

    typedef struct {
        logic [DATA_W-1:0] value;
        status_t           code;
        logic [OCC_W-1:0]  fill;
    } deque_result_t;

    logic [DATA_W-1:0] ring_mem [DEPTH];
    int unsigned       head_slot;
    int unsigned       tail_slot;
    int unsigned       fill_count;
    deque_result_t     expected_results [$];
    int                fails;
    int                reported;
    int                seen;
    int                full_hits;
    int                empty_hits;

    function automatic int unsigned slot_after(input int unsigned i);
        return (i + 1 >= DEPTH) ? 0 : i + 1;
    endfunction

    function automatic int unsigned slot_before(input int unsigned i);
        return (i == 0) ? DEPTH - 1 : i - 1;
    endfunction

    // apply one request to the tracked deque and form its result
    task automatic apply_request(input op_t op, input logic [DATA_W-1:0] val,
                                 output deque_result_t res);
        res.value = '0;
        res.code  = ST_OK;
        if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK)
        begin
            if (fill_count >= DEPTH)
            begin
                res.code = ST_FULL;
            end
            else if (op == OP_PUSH_FRONT)
            begin
                head_slot = slot_before(head_slot);
                ring_mem[head_slot] = val;
                fill_count++;
            end
            else
            begin
                ring_mem[tail_slot] = val;
                tail_slot = slot_after(tail_slot);
                fill_count++;
            end
        end
        else
        begin
            if (fill_count == 0)
            begin
                res.code = ST_EMPTY;
            end
            else if (op == OP_POP_FRONT)
            begin
                res.value = ring_mem[head_slot];
                head_slot = slot_after(head_slot);
                fill_count--;
            end
            else
            begin
                tail_slot = slot_before(tail_slot);
                res.value = ring_mem[tail_slot];
                fill_count--;
            end
        end
        res.fill = fill_count[OCC_W-1:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        deque_result_t exp_res;
        if (!rst_n)
        begin
            head_slot  = 0;
            tail_slot  = 0;
            fill_count = 0;
            fails      = 0;
            reported   = 0;
            seen       = 0;
            full_hits  = 0;
            empty_hits = 0;
            expected_results.delete();
        end
        else
        begin
            // predict first so a result in the same cycle as its request would still find its entry
            if (start && !busy)
            begin
                apply_request(op_t'(opcode), push_value, exp_res);
                expected_results.insert(expected_results.size(), exp_res);
            end
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    fails++;
                    if (reported < 10)
                    begin
                        reported++;
                        $display("unexpected result: value %0d status %0d occupancy %0d",
                                 popped_value, status, occupancy);
                    end
                end
                else
                begin
                    exp_res = expected_results[0];
                    expected_results.delete(0);
                    seen++;
                    if (exp_res.code == ST_FULL)
                        full_hits++;
                    if (exp_res.code == ST_EMPTY)
                        empty_hits++;
                    if (popped_value !== exp_res.value || status !== exp_res.code
                        || occupancy !== exp_res.fill)
                    begin
                        fails++;
                        if (reported < 10)
                        begin
                            reported++;
                            $display("mismatch at %0t: expected %0d status %0d occ %0d",
                                     $realtime, $signed(exp_res.value), exp_res.code,
                                     exp_res.fill);
                            $display("    got value %0d status %0d occ %0d",
                                     popped_value, status, occupancy);
                        end
                    end
                end
            end
        end
        pending        <= expected_results.size();
        fail_count     <= fails;
        checked        <= seen;
        full_refusals  <= full_hits;
        empty_refusals <= empty_hits;
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

// deque testbench: drives requests in bursts, the checker predicts and compares
module tb_top;

    import deq_pkg::*;

    localparam int WATCHDOG_LIMIT = 200;   // cycles with no handshake at all
    localparam int DRAIN_CYCLES   = 8;     // settle time after the last result

    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     start      = 1'b0;
    logic [1:0]               opcode     = OP_PUSH_FRONT;
    logic signed [DATA_W-1:0] push_value = '0;

    wire                      busy;
    wire                      done;
    wire signed [DATA_W-1:0]  popped_value;
    wire [1:0]                status;
    wire [OCC_W-1:0]          occupancy;

    int fail_count;
    int pending;
    int checked;
    int full_refusals;
    int empty_refusals;

    int requests_sent = 0;
    int burst_left    = 0;
    int idle_cycles   = 0;

    // 8 ns clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    double_ended_queue dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .push_value   (push_value),
        .done         (done),
        .popped_value (popped_value),
        .status       (status),
        .occupancy    (occupancy)
    );

    deque_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .push_value     (push_value),
        .done           (done),
        .popped_value   (popped_value),
        .status         (status),
        .occupancy      (occupancy),
        .fail_count     (fail_count),
        .pending        (pending),
        .checked        (checked),
        .full_refusals  (full_refusals),
        .empty_refusals (empty_refusals)
    );

    // watchdog: any request accepted or result seen resets the count
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // issue one request and hold it until the block takes it
    // bursts of random length, separated by random gaps; now and then a long
    // burst so the block also sees back-to-back requests for a while
    task automatic send_request(input op_t op, input logic [DATA_W-1:0] val);
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            if ($urandom_range(0, 7) == 0)
                burst_left = $urandom_range(60, 120);
            else
                burst_left = $urandom_range(1, 24);
        end
        start      <= 1'b1;
        opcode     <= op;
        push_value <= val;
        // busy is sampled as it stood at the edge
        do
            @(posedge clk);
        while (busy);
        burst_left--;
        requests_sent++;
    endtask

    // push data: extremes, single bits, small numbers and full random words
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            4:       return 32'h1 << $urandom_range(0, 31);
            5:       return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    // push_pct steers the fill level: high drives toward full, low toward empty
    task automatic random_request(input int push_pct);
        op_t op;
        if ($urandom_range(0, 99) < push_pct)
            op = ($urandom_range(0, 1) == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        else
            op = ($urandom_range(0, 1) == 0) ? OP_POP_FRONT : OP_POP_BACK;
        // pops carry random data too, it must be ignored
        send_request(op, pick_value());
    endtask

    initial
    begin
        // reset held low from the start, released once
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pops on an empty deque from both ends, with junk data attached
        send_request(OP_POP_FRONT, 32'h0000_0000);
        send_request(OP_POP_BACK,  32'hDEAD_BEEF);
        // front push from slot zero wraps the front pointer to the top
        send_request(OP_PUSH_FRONT, 32'h8000_0000);
        send_request(OP_PUSH_BACK,  32'h7FFF_FFFF);
        send_request(OP_PUSH_FRONT, 32'h0000_0000);
        send_request(OP_PUSH_BACK,  32'hFFFF_FFFF);
        // drain from both ends, crossing the wrap point, then pop the empty deque
        send_request(OP_POP_FRONT, 32'h0000_0000);
        send_request(OP_POP_BACK,  32'h0000_0000);
        send_request(OP_POP_BACK,  32'h0000_0000);
        send_request(OP_POP_FRONT, 32'h0000_0000);
        send_request(OP_POP_BACK,  32'h0000_0000);
        // alternating bit patterns through the store
        send_request(OP_PUSH_BACK,  32'hAAAA_AAAA);
        send_request(OP_PUSH_BACK,  32'h5555_5555);
        send_request(OP_POP_FRONT,  32'hFFFF_FFFF);
        send_request(OP_POP_FRONT,  32'h0000_0000);
        // push front then pop back of a single entry
        send_request(OP_PUSH_FRONT, 32'h0000_0001);
        send_request(OP_POP_BACK,   32'h0000_0000);
        send_request(OP_POP_FRONT,  32'h0000_0000);

        // mixed traffic, then fill past full, drain past empty, mix again
        repeat (100) random_request(50);
        repeat (400) random_request(88);
        repeat (380) random_request(10);
        repeat (70)  random_request(50);

        start <= 1'b0;
        // let the last acceptance reach the checker before looking at pending
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests, %0d results checked", requests_sent, checked);
        $display("refusals seen: %0d pops on empty, %0d pushes on full",
                 empty_refusals, full_refusals);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
